/* rtl/core/assert_macros.svh */
// Assertion macros shared by the forward-probability core.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HFP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define HFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HFP_ASSERT(lbl, clk, rstn, prop, msg)
`define HFP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/core/hfp_pkg.sv */
// Shared types and codes for the forward-probability core.
// No dependencies.
package hfp_pkg;

    localparam logic [1:0] OP_LOAD_INIT  = 2'd0;
    localparam logic [1:0] OP_LOAD_TRANS = 2'd1;
    localparam logic [1:0] OP_LOAD_EMIS  = 2'd2;
    localparam logic [1:0] OP_OBSERVE    = 2'd3;

    localparam logic FP_MUL = 1'b0;
    localparam logic FP_ADD = 1'b1;

    localparam int RUN_CAP = 8;

    localparam logic [63:0] FP_ZERO        = 64'h0000_0000_0000_0000;
    localparam logic [63:0] FP_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

    typedef struct packed {
        logic start;
        logic op;
    } fpu_req_t;

    typedef struct packed {
        logic init_we;
        logic trans_we;
        logic emis_we;
    } tbl_wr_t;

endpackage

/* rtl/core/hfp_fpu.sv */
// Iterative binary64 multiply / add unit, round to nearest even.
// Depends on hfp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module hfp_fpu import hfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  fpu_req_t    req,
    input  logic [63:0] opa,
    input  logic [63:0] opb,
    output logic        done,
    output logic [63:0] result
);

    localparam logic [2:0] F_IDLE   = 3'd0;
    localparam logic [2:0] F_PREP   = 3'd1;
    localparam logic [2:0] F_MUL    = 3'd2;
    localparam logic [2:0] F_NORM   = 3'd3;
    localparam logic [2:0] F_DENORM = 3'd4;
    localparam logic [2:0] F_ROUND  = 3'd5;

    function automatic logic [106:0] shr_sticky(input logic [106:0] v, input logic [7:0] amt);
        logic [106:0] r;
        logic [106:0] lost;
        r    = v >> amt;
        lost = v & ~({107{1'b1}} << amt);
        r[0] = r[0] | (|lost);
        return r;
    endfunction

    logic [2:0]         state_reg;
    logic [63:0]        a_reg, b_reg;
    logic               op_reg;
    logic [106:0]       n_reg;
    logic signed [13:0] e_reg;
    logic               s_reg;
    logic [2:0]         cnt_reg;
    logic [53:0]        pp_reg;
    logic [1:0]         ppsel_reg;
    logic [63:0]        res_reg;
    logic               done_reg;

    // operand fields
    logic        sa, sb, a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
    logic [52:0] ma, mb;
    logic [10:0] ea, eb;

    always_comb begin
        sa     = a_reg[63];
        sb     = b_reg[63];
        a_zero = (a_reg[62:52] == 11'd0) && (a_reg[51:0] == 52'd0);
        b_zero = (b_reg[62:52] == 11'd0) && (b_reg[51:0] == 52'd0);
        a_inf  = (a_reg[62:52] == 11'h7FF) && (a_reg[51:0] == 52'd0);
        b_inf  = (b_reg[62:52] == 11'h7FF) && (b_reg[51:0] == 52'd0);
        a_nan  = (a_reg[62:52] == 11'h7FF) && (a_reg[51:0] != 52'd0);
        b_nan  = (b_reg[62:52] == 11'h7FF) && (b_reg[51:0] != 52'd0);
        ma     = {a_reg[62:52] != 11'd0, a_reg[51:0]};
        mb     = {b_reg[62:52] != 11'd0, b_reg[51:0]};
        ea     = (a_reg[62:52] == 11'd0) ? 11'd1 : a_reg[62:52];
        eb     = (b_reg[62:52] == 11'd0) ? 11'd1 : b_reg[62:52];
    end

    // special operands
    logic        special;
    logic [63:0] special_val;

    always_comb begin
        special     = 1'b1;
        special_val = FP_DEFAULT_NAN;
        if (a_nan) begin
            special_val = a_reg | 64'h0008_0000_0000_0000;
        end else if (b_nan) begin
            special_val = b_reg | 64'h0008_0000_0000_0000;
        end else if (op_reg == FP_MUL) begin
            if ((a_inf && b_zero) || (a_zero && b_inf)) begin
                special_val = FP_DEFAULT_NAN;
            end else if (a_inf || b_inf) begin
                special_val = {sa ^ sb, 11'h7FF, 52'd0};
            end else if (a_zero || b_zero) begin
                special_val = {sa ^ sb, 63'd0};
            end else begin
                special = 1'b0;
            end
        end else begin
            if (a_inf && b_inf && (sa != sb)) begin
                special_val = FP_DEFAULT_NAN;
            end else if (a_inf) begin
                special_val = a_reg;
            end else if (b_inf) begin
                special_val = b_reg;
            end else if (a_zero && b_zero) begin
                special_val = {sa & sb, 63'd0};
            end else if (a_zero) begin
                special_val = b_reg;
            end else if (b_zero) begin
                special_val = a_reg;
            end else begin
                special = 1'b0;
            end
        end
    end

    // add alignment
    logic         a_big;
    logic [52:0]  m_big, m_sml;
    logic [10:0]  e_big, e_sml, e_diff;
    logic [7:0]   align_amt;
    logic [106:0] sml_sh, big_v, add_sum;

    always_comb begin
        a_big     = a_reg[62:0] >= b_reg[62:0];
        m_big     = a_big ? ma : mb;
        m_sml     = a_big ? mb : ma;
        e_big     = a_big ? ea : eb;
        e_sml     = a_big ? eb : ea;
        e_diff    = e_big - e_sml;
        align_amt = (e_diff > 11'd255) ? 8'd255 : e_diff[7:0];
        big_v     = {1'b0, m_big, 53'd0};
        sml_sh    = shr_sticky({1'b0, m_sml, 53'd0}, align_amt);
        add_sum   = (sa == sb) ? (big_v + sml_sh) : (big_v - sml_sh);
    end

    // partial products: one 27x27 multiplier, four passes
    logic [26:0]  mx, my;
    logic [53:0]  pp;
    logic [106:0] pp_shifted;

    always_comb begin
        mx = cnt_reg[1] ? {1'b0, ma[52:27]} : ma[26:0];
        my = cnt_reg[0] ? {1'b0, mb[52:27]} : mb[26:0];
        pp = mx * my;
        case (ppsel_reg)
            2'd0:    pp_shifted = 107'(pp_reg);
            2'd3:    pp_shifted = 107'(pp_reg) << 54;
            default: pp_shifted = 107'(pp_reg) << 27;
        endcase
    end

    // normalize step
    logic               norm_done;
    logic [106:0]       n_step;
    logic signed [13:0] e_step;

    always_comb begin
        norm_done = !n_reg[106] && (n_reg[105] || (n_reg == 107'd0) || (e_reg <= 14'sd1));
        if (n_reg[106]) begin
            n_step = {1'b0, n_reg[106:2], n_reg[1] | n_reg[0]};
            e_step = e_reg + 14'sd1;
        end else if ((n_reg[105:90] == 16'd0) && (e_reg > 14'sd16)) begin
            n_step = n_reg << 16;
            e_step = e_reg - 14'sd16;
        end else if ((n_reg[105:102] == 4'd0) && (e_reg > 14'sd4)) begin
            n_step = n_reg << 4;
            e_step = e_reg - 14'sd4;
        end else begin
            n_step = n_reg << 1;
            e_step = e_reg - 14'sd1;
        end
    end

    // subnormal shift
    logic signed [13:0] one_minus_e;
    logic [7:0]         den_amt;

    always_comb begin
        one_minus_e = 14'sd1 - e_reg;
        den_amt     = (one_minus_e > 14'sd255) ? 8'd255 : one_minus_e[7:0];
    end

    // rounding
    logic [55:0]        m56;
    logic               rnd_st, rnd_up;
    logic [53:0]        sum54;
    logic [52:0]        sig_f;
    logic signed [13:0] e_f;
    logic [63:0]        rnd_val;

    always_comb begin
        m56    = n_reg[105:50];
        rnd_st = |n_reg[49:0];
        rnd_up = m56[2] & (m56[1] | m56[0] | rnd_st | m56[3]);
        sum54  = {1'b0, m56[55:3]} + 54'(rnd_up);
        if (sum54[53]) begin
            sig_f = sum54[53:1];
            e_f   = e_reg + 14'sd1;
        end else begin
            sig_f = sum54[52:0];
            e_f   = e_reg;
        end
        if (n_reg == 107'd0) begin
            rnd_val = FP_ZERO;
        end else if (e_f >= 14'sd2047) begin
            rnd_val = {s_reg, 11'h7FF, 52'd0};
        end else begin
            rnd_val = {s_reg, sig_f[52] ? e_f[10:0] : 11'd0, sig_f[51:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= 3'd0;
        end else begin
            // pulse done as the result lands in res_reg
            done_reg <= (state_reg == F_ROUND) || ((state_reg == F_PREP) && special);
            case (state_reg)
                F_IDLE: begin
                    if (req.start) begin
                        a_reg     <= opa;
                        b_reg     <= opb;
                        op_reg    <= req.op;
                        state_reg <= F_PREP;
                    end
                end
                F_PREP: begin
                    if (special) begin
                        res_reg   <= special_val;
                        state_reg <= F_IDLE;
                    end else if (op_reg == FP_MUL) begin
                        n_reg     <= 107'd0;
                        e_reg     <= $signed({3'd0, ea}) + $signed({3'd0, eb}) - 14'sd1022;
                        s_reg     <= sa ^ sb;
                        cnt_reg   <= 3'd0;
                        state_reg <= F_MUL;
                    end else begin
                        n_reg     <= add_sum;
                        e_reg     <= $signed({3'd0, e_big});
                        s_reg     <= a_big ? sa : sb;
                        state_reg <= F_NORM;
                    end
                end
                F_MUL: begin
                    if (cnt_reg != 3'd4) begin
                        pp_reg    <= pp;
                        ppsel_reg <= cnt_reg[1:0];
                    end
                    if (cnt_reg != 3'd0) begin
                        n_reg <= n_reg + pp_shifted;
                    end
                    if (cnt_reg == 3'd4) begin
                        state_reg <= F_NORM;
                    end
                    cnt_reg <= cnt_reg + 3'd1;
                end
                F_NORM: begin
                    if (norm_done) begin
                        state_reg <= F_DENORM;
                    end else begin
                        n_reg <= n_step;
                        e_reg <= e_step;
                    end
                end
                F_DENORM: begin
                    if (e_reg < 14'sd1) begin
                        n_reg <= shr_sticky(n_reg, den_amt);
                        e_reg <= 14'sd1;
                    end
                    state_reg <= F_ROUND;
                end
                F_ROUND: begin
                    res_reg   <= rnd_val;
                    state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    `HFP_ASSERT(a_fpu_start_idle, aclk, aresetn,
        req.start |-> (state_reg == F_IDLE), "fpu start while busy")
    `HFP_ASSERT(a_fpu_done_pulse, aclk, aresetn,
        done_reg |=> !done_reg, "fpu done longer than one cycle")
    `HFP_ASSERT(a_fpu_norm_exp, aclk, aresetn,
        (state_reg == F_ROUND) |-> (e_reg >= 14'sd1), "round entered below minimum exponent")

endmodule

/* rtl/core/hfp_tables.sv */
// Initial, transition and emission probability memories.
// Depends on hfp_pkg.
module hfp_tables import hfp_pkg::*; #(
    parameter int NUM_STATES  = 8,
    parameter int NUM_SYMBOLS = 16,
    parameter int IDX_W       = 3
) (
    input  logic             aclk,
    input  tbl_wr_t          wr,
    input  logic [2:0]       wr_row,
    input  logic [3:0]       wr_col,
    input  logic [63:0]      wr_data,
    input  logic [IDX_W-1:0] rd_state,
    input  logic [IDX_W-1:0] rd_src,
    input  logic [3:0]       rd_sym,
    output logic [63:0]      init_q,
    output logic [63:0]      trans_q,
    output logic [63:0]      emis_q
);

    localparam int TR_DEPTH = NUM_STATES * NUM_STATES;
    localparam int EM_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int TR_AW    = (TR_DEPTH > 1) ? $clog2(TR_DEPTH) : 1;
    localparam int EM_AW    = $clog2(EM_DEPTH);

    logic [63:0] init_mem  [NUM_STATES];
    logic [63:0] trans_mem [TR_DEPTH];
    logic [63:0] emis_mem  [EM_DEPTH];

    logic             row_ok, trans_ok, emis_ok, sym_oor;
    logic [IDX_W-1:0] wr_init_addr;
    logic [TR_AW-1:0] wr_tr_addr, rd_tr_addr;
    logic [EM_AW-1:0] wr_em_addr, rd_em_addr;
    logic [63:0]      emis_raw_q;
    logic             sym_oor_q;

    always_comb begin
        row_ok       = 32'(wr_row) < NUM_STATES;
        trans_ok     = row_ok && (32'(wr_col) < NUM_STATES);
        emis_ok      = row_ok && (32'(wr_col) < NUM_SYMBOLS);
        sym_oor      = 32'(rd_sym) >= NUM_SYMBOLS;
        wr_init_addr = IDX_W'(wr_row);
        wr_tr_addr   = TR_AW'(32'(wr_row) * NUM_STATES + 32'(wr_col));
        wr_em_addr   = EM_AW'(32'(wr_row) * NUM_SYMBOLS + 32'(wr_col));
        rd_tr_addr   = TR_AW'(32'(rd_src) * NUM_STATES + 32'(rd_state));
        rd_em_addr   = EM_AW'(32'(rd_state) * NUM_SYMBOLS + 32'(rd_sym));
    end

    always_ff @(posedge aclk) begin
        if (wr.init_we && row_ok) begin
            init_mem[wr_init_addr] <= wr_data;
        end
        if (wr.trans_we && trans_ok) begin
            trans_mem[wr_tr_addr] <= wr_data;
        end
        if (wr.emis_we && emis_ok) begin
            emis_mem[wr_em_addr] <= wr_data;
        end
        init_q     <= init_mem[rd_state];
        trans_q    <= trans_mem[rd_tr_addr];
        emis_raw_q <= emis_mem[rd_em_addr];
        sym_oor_q  <= sym_oor;
    end

    // symbols past the table read as +0.0
    assign emis_q = sym_oor_q ? FP_ZERO : emis_raw_q;

endmodule

/* rtl/core/hmm_forward_probability_core.sv */
// Top level of the hidden Markov model forward-pass core.
// Depends on hfp_pkg, hfp_fpu, hfp_tables and assert_macros.svh.
//
// Usage:
//  - Input channel (s_*): one beat per item. op selects load of the initial,
//    transition or emission table, or an observation. Loads produce nothing;
//    observations produce one m_* beat per active state.
//  - Result channel (m_*): state_index, alpha_value (binary64 bits) and
//    last_of_run, in ascending state order.
//  - APB port: register 0 (address 0) holds active_states, reset 8,
//    clamped to 1..min(NUM_STATES, 8) when an observation starts.
//  - All arithmetic runs through one iterative binary64 unit: a multiply
//    forms four 27x27 partial products, then normalizes and rounds; an add
//    aligns, normalizes and rounds. An observation that continues a sequence
//    takes, for each active state, one multiply and one add per source state
//    and a final multiply by the emission; at a sequence start, one multiply
//    per state.
//  - s_ready is high only between items. A finished result waits in the
//    output register; while the receiver stalls, the sequencer holds before
//    loading the next state's result, so nothing is dropped.
//  - Reset (aresetn low, synchronous) clears the forward values to +0.0 and
//    active_states to 8; table contents are undefined until loaded.
`include "assert_macros.svh"
module hmm_forward_probability_core import hfp_pkg::*; #(
    parameter int NUM_STATES  = 8,
    parameter int NUM_SYMBOLS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [2:0]  s_row_index,
    input  logic [3:0]  s_col_index,
    input  logic [63:0] s_prob_value,
    input  logic [3:0]  s_symbol,
    input  logic        s_seq_start,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_state_index,
    output logic [63:0] m_alpha_value,
    output logic        m_last_of_run,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RUN_N = (NUM_STATES < RUN_CAP) ? NUM_STATES : RUN_CAP;
    localparam int RUN_W = (RUN_N > 1) ? $clog2(RUN_N) : 1;
    localparam int IDX_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_WMUL  = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_WADD  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [RUN_W-1:0] j_reg, p_reg, last_reg;
    logic             start_reg, final_reg;
    logic [3:0]       sym_reg;
    logic [63:0]      acc_reg;
    logic [63:0]      alpha_reg [RUN_N];
    logic [63:0]      nxt_reg   [RUN_N];
    logic [3:0]       active_reg;

    logic             m_valid_reg, m_last_reg;
    logic [2:0]       m_idx_reg;
    logic [63:0]      m_val_reg;

    logic             s_fire, obs_fire, out_load;
    logic [RUN_W-1:0] run_last;
    tbl_wr_t          tbl_wr;
    fpu_req_t         fpu_req;
    logic [63:0]      fpu_a, fpu_b, fpu_res;
    logic             fpu_done;
    logic [63:0]      init_q, trans_q, emis_q;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {28'd0, active_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 4'd8;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            active_reg <= pwdata[3:0];
        end
    end

    // clamp active count; hold the index of the last state of the run
    always_comb begin
        if (active_reg == 4'd0) begin
            run_last = '0;
        end else if (32'(active_reg) >= RUN_N) begin
            run_last = RUN_W'(RUN_N - 1);
        end else begin
            run_last = RUN_W'(active_reg - 4'd1);
        end
    end

    // ---------------- input side ----------------
    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign obs_fire = s_fire && (s_op == OP_OBSERVE);

    always_comb begin
        tbl_wr.init_we  = s_fire && (s_op == OP_LOAD_INIT);
        tbl_wr.trans_we = s_fire && (s_op == OP_LOAD_TRANS);
        tbl_wr.emis_we  = s_fire && (s_op == OP_LOAD_EMIS);
    end

    hfp_tables #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS),
        .IDX_W       (IDX_W)
    ) u_tables (
        .aclk     (aclk),
        .wr       (tbl_wr),
        .wr_row   (s_row_index),
        .wr_col   (s_col_index),
        .wr_data  (s_prob_value),
        .rd_state (IDX_W'(j_reg)),
        .rd_src   (IDX_W'(p_reg)),
        .rd_sym   (sym_reg),
        .init_q   (init_q),
        .trans_q  (trans_q),
        .emis_q   (emis_q)
    );

    // ---------------- shared arithmetic unit ----------------
    always_comb begin
        fpu_req.start = (state_reg == S_MUL) || (state_reg == S_ADD);
        fpu_req.op    = (state_reg == S_ADD) ? FP_ADD : FP_MUL;
        if (state_reg == S_ADD) begin
            fpu_a = acc_reg;
            fpu_b = fpu_res;
        end else if (final_reg) begin
            fpu_a = acc_reg;
            fpu_b = emis_q;
        end else if (start_reg) begin
            fpu_a = init_q;
            fpu_b = emis_q;
        end else begin
            fpu_a = trans_q;
            fpu_b = alpha_reg[p_reg];
        end
    end

    hfp_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (fpu_req),
        .opa     (fpu_a),
        .opb     (fpu_b),
        .done    (fpu_done),
        .result  (fpu_res)
    );

    // ---------------- sequencer ----------------
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (obs_fire) state_next = S_FETCH;
            S_FETCH: state_next = S_MUL;
            S_MUL:   state_next = S_WMUL;
            S_WMUL: begin
                if (fpu_done) begin
                    state_next = (start_reg || final_reg) ? S_OUT : S_ADD;
                end
            end
            S_ADD:   state_next = S_WADD;
            S_WADD: begin
                if (fpu_done) begin
                    state_next = (p_reg == last_reg) ? S_MUL : S_FETCH;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = (j_reg == last_reg) ? S_IDLE : S_FETCH;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            j_reg       <= '0;
            p_reg       <= '0;
            final_reg   <= 1'b0;
            for (int i = 0; i < RUN_N; i++) begin
                alpha_reg[i] <= FP_ZERO;
            end
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (obs_fire) begin
                        j_reg     <= '0;
                        p_reg     <= '0;
                        last_reg  <= run_last;
                        start_reg <= s_seq_start;
                        sym_reg   <= s_symbol;
                        final_reg <= 1'b0;
                        acc_reg   <= FP_ZERO;
                    end
                end
                S_WADD: begin
                    if (fpu_done) begin
                        acc_reg <= fpu_res;
                        if (p_reg == last_reg) begin
                            final_reg <= 1'b1;
                        end else begin
                            p_reg <= p_reg + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        // hand the result to the output register
                        m_valid_reg    <= 1'b1;
                        m_idx_reg      <= 3'(j_reg);
                        m_val_reg      <= fpu_res;
                        m_last_reg     <= (j_reg == last_reg);
                        nxt_reg[j_reg] <= fpu_res;
                        if (j_reg == last_reg) begin
                            // commit the new forward values of the run
                            for (int i = 0; i < RUN_N; i++) begin
                                if (RUN_W'(i) < j_reg) begin
                                    alpha_reg[i] <= nxt_reg[i];
                                end
                            end
                            alpha_reg[j_reg] <= fpu_res;
                        end else begin
                            j_reg     <= j_reg + 1'b1;
                            p_reg     <= '0;
                            acc_reg   <= FP_ZERO;
                            final_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_state_index = m_idx_reg;
    assign m_alpha_value = m_val_reg;
    assign m_last_of_run = m_last_reg;

    `HFP_ASSERT(a_done_when_waiting, aclk, aresetn,
        fpu_done |-> (state_reg == S_WMUL || state_reg == S_WADD), "fpu result with no waiter")
    `HFP_ASSERT(a_add_only_in_sum, aclk, aresetn,
        (state_reg == S_WADD) |-> (!final_reg && !start_reg), "accumulate outside the sum phase")
    `HFP_ASSERT(a_run_ends_on_last, aclk, aresetn,
        (state_reg == S_OUT && state_next == S_IDLE) |-> (j_reg == last_reg), "run ended early")

endmodule

/* bench/hmm_forward_checker.sv */
// Scoreboard for the HMM forward-pass core: snoops the APB port and both streams,
// predicts every result beat in binary64 and compares it. Depends on hfp_pkg.
module hmm_forward_checker import hfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [2:0]  s_row_index,
    input  logic [3:0]  s_col_index,
    input  logic [63:0] s_prob_value,
    input  logic [3:0]  s_symbol,
    input  logic        s_seq_start,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_state_index,
    input  logic [63:0] m_alpha_value,
    input  logic        m_last_of_run,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          alpha_pending,
    output int          alpha_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ST  = 8;
    localparam int N_SYM = 16;
    localparam int REG_ACTIVE_STATES = 0;

    typedef struct packed {
        logic [2:0]  state_index;
        logic [63:0] alpha_value;
        logic        last_of_run;
    } alpha_beat_t;

    real         init_tbl  [N_ST];
    real         trans_tbl [N_ST*N_ST];
    real         emis_tbl  [N_ST*N_SYM];
    real         fwd       [N_ST];
    logic [3:0]  active_cfg;
    alpha_beat_t alpha_q[$];

    function automatic bit is_nan(logic [63:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != 0);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic forward_step(logic [3:0] sym, logic start);
        real         nxt[N_ST];
        real         acc;
        real         prod;
        int          n;
        alpha_beat_t b;
        n = (active_cfg < 1) ? 1 : (active_cfg > N_ST ? N_ST : int'(active_cfg));
        for (int j = 0; j < n; j++) begin
            if (start) begin
                nxt[j] = init_tbl[j] * emis_tbl[j*N_SYM + sym];
            end else begin
                acc = 0.0;
                for (int p = 0; p < n; p++) begin
                    prod = trans_tbl[p*N_ST + j] * fwd[p];
                    acc = acc + prod;
                end
                nxt[j] = acc * emis_tbl[j*N_SYM + sym];
            end
        end
        for (int j = 0; j < n; j++) begin
            fwd[j] = nxt[j];
            b.state_index = j[2:0];
            b.alpha_value = $realtobits(nxt[j]);
            b.last_of_run = (j == n - 1);
            alpha_q.push_back(b);
        end
    endtask

    always @(posedge aclk) begin
        alpha_beat_t want;
        if (!aresetn) begin
            for (int i = 0; i < N_ST; i++) fwd[i] = 0.0;
            active_cfg = 4'd8;
            alpha_q.delete();
        end else begin
            if (psel && penable && pwrite && pready && (paddr >> 2) == REG_ACTIVE_STATES)
                active_cfg = pwdata[3:0];
            if (s_valid && s_ready) begin
                case (s_op)
                    OP_LOAD_INIT:  init_tbl[s_row_index] = $bitstoreal(s_prob_value);
                    OP_LOAD_TRANS: if (s_col_index < N_ST)
                        trans_tbl[s_row_index*N_ST + s_col_index] = $bitstoreal(s_prob_value);
                    OP_LOAD_EMIS:  emis_tbl[s_row_index*N_SYM + s_col_index] =
                        $bitstoreal(s_prob_value);
                    OP_OBSERVE:    forward_step(s_symbol, s_seq_start);
                endcase
            end
            if (m_valid && m_ready) begin
                alpha_seen++;
                if (alpha_q.size() == 0) begin
                    report_mismatch("unexpected beat", m_alpha_value, '0);
                end else begin
                    want = alpha_q.pop_front();
                    if (m_state_index != want.state_index)
                        report_mismatch("state_index", m_state_index, want.state_index);
                    // NaN payloads are not pinned down; any NaN matches a NaN
                    if (!(is_nan(want.alpha_value) && is_nan(m_alpha_value)) &&
                        m_alpha_value !== want.alpha_value)
                        report_mismatch("alpha_value", m_alpha_value, want.alpha_value);
                    if (m_last_of_run != want.last_of_run)
                        report_mismatch("last_of_run", m_last_of_run, want.last_of_run);
                end
            end
        end
        alpha_pending = alpha_q.size();
    end

    initial begin
        fail_count = 0;
        alpha_pending = 0;
        alpha_seen = 0;
        for (int i = 0; i < N_ST*N_SYM; i++) emis_tbl[i] = 0.0;
        for (int i = 0; i < N_ST*N_ST; i++) trans_tbl[i] = 0.0;
        for (int i = 0; i < N_ST; i++) init_tbl[i] = 0.0;
    end
endmodule

/* bench/tb_hmm_forward_probability_core.sv */
// Top of the HMM forward-pass core bench: clock, reset, stimulus and verdict.
// Depends on hfp_pkg, hmm_forward_probability_core and hmm_forward_checker.
module tb_hmm_forward_probability_core import hfp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         N_ST  = 8;
    localparam int         N_SYM = 16;
    localparam logic [2:0] ADDR_ACTIVE_STATES = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED      = 3'd4;
    localparam int         SETTLE_CYCLES      = 50;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_op = OP_LOAD_INIT;
    logic [2:0]  s_row_index = '0;
    logic [3:0]  s_col_index = '0;
    logic [63:0] s_prob_value = '0;
    logic [3:0]  s_symbol = '0;
    logic        s_seq_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_state_index;
    logic [63:0] m_alpha_value;
    logic        m_last_of_run;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int alpha_pending;
    int alpha_seen;
    int items_sent = 0;
    bit no_idle = 1'b0;   // long stretch where neither side stalls

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    hmm_forward_probability_core u_dut (.*);

    hmm_forward_checker u_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_op, .s_row_index, .s_col_index,
        .s_prob_value, .s_symbol, .s_seq_start, .m_valid, .m_ready, .m_state_index,
        .m_alpha_value, .m_last_of_run, .psel, .penable, .pwrite, .paddr, .pwdata,
        .pready, .fail_count, .alpha_pending, .alpha_seen
    );

    // Stall the result side about 27% of the time outside the calm stretch.
    always @(posedge aclk)
        m_ready <= no_idle || ($urandom_range(99) >= 27);

    // Draw a well-formed probability in [0,1).
    function automatic logic [63:0] rand_prob();
        real r;
        r = real'($urandom) / 4294967296.0;
        return $realtobits(r);
    endfunction

    // Send one beat. Drop valid only when an idle gap is taken, so valid
    // never falls and rises within one step.
    task automatic send_beat(logic [1:0] op, logic [2:0] row, logic [3:0] col,
                             logic [63:0] prob, logic [3:0] sym, logic start);
        if (!no_idle && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_row_index  <= row;
        s_col_index  <= col;
        s_prob_value <= prob;
        s_symbol     <= sym;
        s_seq_start  <= start;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Load with unused fields randomized.
    task automatic load_entry(logic [1:0] op, logic [2:0] row, logic [3:0] col,
                              logic [63:0] prob);
        send_beat(op, row, col, prob, 4'($urandom), 1'($urandom));
    endtask

    task automatic observe(logic [3:0] sym, logic start);
        send_beat(OP_OBSERVE, 3'($urandom), 4'($urandom), {$urandom, $urandom}, sym, start);
    endtask

    // Drain every expected beat and let the core settle, then leave valid low.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (alpha_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random traffic: mostly sequences of observations with fresh table
    // entries sprinkled in, plus ignored loads and out-of-place continuations.
    task automatic random_phase(int n_items);
        int done_items;
        int pick;
        done_items = 0;
        while (done_items < n_items) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                observe(4'($urandom), 1'b1);
                repeat ($urandom_range(0, 3)) begin
                    observe(4'($urandom), 1'b0);
                    done_items++;
                end
            end else if (pick < 85) begin
                case ($urandom_range(2))
                    0: load_entry(OP_LOAD_INIT, 3'($urandom), 4'($urandom), rand_prob());
                    1: load_entry(OP_LOAD_TRANS, 3'($urandom), 4'($urandom_range(7)),
                                  rand_prob());
                    default: load_entry(OP_LOAD_EMIS, 3'($urandom), 4'($urandom),
                                        rand_prob());
                endcase
            end else if (pick < 93) begin
                // out-of-range destination: ignored, so any bit pattern is harmless
                load_entry(OP_LOAD_TRANS, 3'($urandom), 4'($urandom_range(8, 15)),
                           {$urandom, $urandom});
            end else begin
                observe(4'($urandom), 1'b0);
            end
            done_items++;
        end
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill every table entry so no observation reads an unwritten one.
        for (int i = 0; i < N_ST; i++)
            load_entry(OP_LOAD_INIT, 3'(i), 4'($urandom), rand_prob());
        for (int i = 0; i < N_ST*N_ST; i++)
            load_entry(OP_LOAD_TRANS, 3'(i / N_ST), 4'(i % N_ST), rand_prob());
        for (int i = 0; i < N_ST*N_SYM; i++)
            load_entry(OP_LOAD_EMIS, 3'(i / N_SYM), 4'(i % N_SYM), rand_prob());

        // Continue before any start: alpha is still all zero.
        observe(4'd3, 1'b0);

        // Directed corners: field extremes, sign and top exponent bits,
        // subnormals, exact 1.0 and 0.0, ignored loads.
        observe(4'd0, 1'b1);
        observe(4'd15, 1'b0);
        load_entry(OP_LOAD_INIT, 3'd0, 4'd15, 64'h3FF0_0000_0000_0000);
        load_entry(OP_LOAD_INIT, 3'd7, 4'd0, 64'h0000_0000_0000_0000);
        load_entry(OP_LOAD_INIT, 3'd1, 4'd0, 64'hC000_0000_0000_0000);
        load_entry(OP_LOAD_EMIS, 3'd1, 4'd15, 64'h4000_0000_0000_0000);
        load_entry(OP_LOAD_EMIS, 3'd2, 4'd15, 64'h0000_0000_0000_0001);
        load_entry(OP_LOAD_EMIS, 3'd7, 4'd15, 64'h3FEF_FFFF_FFFF_FFFF);
        load_entry(OP_LOAD_TRANS, 3'd7, 4'd7, 64'h3FF0_0000_0000_0000);
        load_entry(OP_LOAD_TRANS, 3'd7, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
        load_entry(OP_LOAD_TRANS, 3'd0, 4'd8, 64'h7FF0_0000_0000_0000);
        observe(4'd15, 1'b1);
        observe(4'd15, 1'b0);
        observe(4'd15, 1'b0);
        observe(4'd0, 1'b0);
        drain();

        // Sweep active_states: max, min, middles, saturation above 8, zero as 1.
        apb_write(ADDR_ACTIVE_STATES, 32'd1);
        random_phase(40);
        apb_write(ADDR_ACTIVE_STATES, 32'd3);
        // unmapped register: must not disturb the count
        apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        no_idle = 1'b1;
        random_phase(50);
        no_idle = 1'b0;
        apb_write(ADDR_ACTIVE_STATES, 32'd5);
        random_phase(40);
        apb_write(ADDR_ACTIVE_STATES, 32'd15);
        random_phase(25);
        apb_write(ADDR_ACTIVE_STATES, 32'd0);
        random_phase(30);
        // Grow back to 4: inactive states' kept values come back into play.
        apb_write(ADDR_ACTIVE_STATES, 32'd4);
        random_phase(35);
        apb_write(ADDR_ACTIVE_STATES, 32'd8);
        random_phase(25);

        $display("Sent %0d input beats and checked %0d result beats", items_sent, alpha_seen);
        $display("across active-state counts 8, 1, 3, 5, 15, 0 and 4.");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end
endmodule

/* hmm_forward_probability_core.f */
+incdir+rtl/core
rtl/core/hfp_pkg.sv
rtl/core/hfp_fpu.sv
rtl/core/hfp_tables.sv
rtl/core/hmm_forward_probability_core.sv
bench/hmm_forward_checker.sv
bench/tb_hmm_forward_probability_core.sv
